// ===== design/priority_queue_linear_scan_macros.svh =====
// ----------------------------------------------------------------------------
// Priority queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_LINEAR_SCAN_MACROS_SVH
`define PRIORITY_QUEUE_LINEAR_SCAN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PQLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PQLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pqls_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority queue package
// Field widths, action codes and status codes of the linear-scan queue.
// ----------------------------------------------------------------------------
package pqls_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int PRIO_IN_BITS   = 8;
    localparam int COUNT_OUT_BITS = 5;
    localparam int STATUS_BITS    = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

// ===== design/pqls_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module pqls_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/priority_queue_linear_scan.sv =====
// ----------------------------------------------------------------------------
// Priority queue with linear scan
// Bounded queue in an unsorted RAM; removes take the highest priority entry.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                        | Direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, action, item_value,        | request
//          | item_priority                                  |
//  out     | out_valid, out_stall, removed_value, status,   | response
//          | entry_count                                    |
//
// An insert writes the entry to the RAM in the cycle the transaction is
// accepted; the result then passes through the finish state into the output
// register. A remove scans with one RAM read per held entry, then does one
// read and one write per cycle while later entries move down over the gap.
// The entry RAM has a single read port, so the scan and the shift read one
// word at a time.
// Reset clears the entry count, the sequencer and the output valid; the RAM
// is not cleared, since only words below the count are ever used.
// The block holds in_stall high from acceptance until its result enters the
// output register; a stalled result only delays that last step.
//
module priority_queue_linear_scan #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic                                       action,
    input  logic signed [pqls_pkg::VALUE_BITS-1:0]     item_value,
    input  logic        [pqls_pkg::PRIO_IN_BITS-1:0]   item_priority,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [pqls_pkg::VALUE_BITS-1:0]     removed_value,
    output logic        [pqls_pkg::STATUS_BITS-1:0]    status,
    output logic        [pqls_pkg::COUNT_OUT_BITS-1:0] entry_count
);

    import pqls_pkg::*;

    `include "priority_queue_linear_scan_macros.svh"

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // One RAM word holds the priority above the value.
    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [VALUE_BITS-1:0]    val;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t                         state_reg,       state_next;
    logic [CW-1:0]                  count_reg,       count_next;
    logic [AW-1:0]                  scan_idx_reg,    scan_idx_next;
    logic [AW-1:0]                  best_idx_reg,    best_idx_next;
    logic [PRIORITY_BITS-1:0]       best_prio_reg,   best_prio_next;
    logic signed [VALUE_BITS-1:0]   res_value_reg,   res_value_next;
    status_t                        res_status_reg,  res_status_next;
    logic [CW-1:0]                  src_reg,         src_next;
    logic [AW-1:0]                  dst_reg,         dst_next;
    logic                           primed_reg,      primed_next;
    logic                           out_valid_reg,   out_valid_next;
    logic signed [VALUE_BITS-1:0]   out_value_reg,   out_value_next;
    logic [STATUS_BITS-1:0]         out_status_reg,  out_status_next;
    logic [COUNT_OUT_BITS-1:0]      out_count_reg,   out_count_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;

    logic [31:0]              prio_wide;
    logic [PRIORITY_BITS-1:0] in_prio;
    logic [31:0]              count_wide;
    logic                     take;
    logic                     scan_last;
    logic                     out_load;

    // Priority bits above PRIORITY_BITS are dropped; narrower inputs are
    // zero extended.
    assign prio_wide  = 32'(item_priority);
    assign in_prio    = prio_wide[PRIORITY_BITS-1:0];
    assign count_wide = 32'(count_reg);

    pqls_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The scan compares the word read last cycle against the best so far.
    // Only a strictly larger priority replaces it, so ties keep the earliest.
    assign take      = (scan_idx_reg == '0) || (ram_rdata.prio > best_prio_reg);
    assign scan_last = ((CW'(scan_idx_reg) + CW'(1)) == count_reg);
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        primed_next     = primed_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && out_stall;

        ram_we    = 1'b0;
        ram_waddr = dst_reg;
        ram_wdata = ram_rdata;
        ram_raddr = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_value_next = '0;
                    state_next     = ST_FINISH;
                    if (action == ACT_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = count_reg[AW-1:0];
                            ram_wdata.prio  = in_prio;
                            ram_wdata.val   = item_value;
                            count_next      = count_reg + CW'(1);
                            res_status_next = STATUS_DONE;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ram_raddr       = '0;
                        scan_idx_next   = '0;
                        res_status_next = STATUS_DONE;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                ram_raddr     = scan_idx_reg + AW'(1);
                scan_idx_next = scan_idx_reg + AW'(1);
                if (take)
                begin
                    best_idx_next  = scan_idx_reg;
                    best_prio_next = ram_rdata.prio;
                    res_value_next = $signed(ram_rdata.val);
                end
                if (scan_last)
                begin
                    dst_next    = best_idx_next;
                    src_next    = CW'(best_idx_next) + CW'(1);
                    primed_next = 1'b0;
                    state_next  = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // Reads run one position ahead of writes: the word read last
                // cycle lands one slot lower this cycle.
                if (primed_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                    dst_next  = dst_reg + AW'(1);
                end
                if (src_reg < count_reg)
                begin
                    ram_raddr   = src_reg[AW-1:0];
                    src_next    = src_reg + CW'(1);
                    primed_next = 1'b1;
                end
                else
                begin
                    primed_next = 1'b0;
                    count_next  = count_reg - CW'(1);
                    state_next  = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_wide[COUNT_OUT_BITS-1:0];
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            best_idx_reg   <= '0;
            best_prio_reg  <= '0;
            res_value_reg  <= '0;
            res_status_reg <= STATUS_DONE;
            src_reg        <= '0;
            dst_reg        <= '0;
            primed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= STATUS_DONE;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            best_idx_reg   <= best_idx_next;
            best_prio_reg  <= best_prio_next;
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            primed_reg     <= primed_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign removed_value = out_value_reg;
    assign status        = out_status_reg;
    assign entry_count   = out_count_reg;

    `PQLS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY),
        "entry count exceeds capacity")

    `PQLS_ASSERT_NEXT(a_count_step, 1'b1,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1)) ||
        (count_reg + CW'(1) == $past(count_reg)),
        "entry count moved by more than one")

    `PQLS_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN,
        CW'(scan_idx_reg) < count_reg, "scan index beyond held entries")

    `PQLS_ASSERT_NOW(a_no_overwrite, out_load, !(out_valid_reg && out_stall),
        "result loaded over a pending result")

    `PQLS_ASSERT_NOW(a_refused_zero,
        out_valid_reg && (out_status_reg != STATUS_DONE), out_value_reg == '0,
        "refused transaction returns a nonzero value")

endmodule

// ===== dv/priority_queue_linear_scan_tb.sv =====
// ----------------------------------------------------------------------------
// Priority queue with linear scan: self-checking testbench
// Drives insert and remove transactions into the queue, predicts every
// response with an independent model of the unsorted store, and compares
// each response field by field under varying source idle and sink stall.
// ----------------------------------------------------------------------------
module priority_queue_linear_scan_tb;

    import pqls_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    // Longer than the longest remove, so this covers any tail.
    localparam int DRAIN_CYCLES  = 2 * CAPACITY + 8;
    localparam int PHASE_ITEMS   = 307;
    localparam int REPORT_LIMIT  = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps a shadow copy of the entry store, works out the
    // response of every accepted request and checks responses in order.
    // ------------------------------------------------------------------------
    class pq_scoreboard;
        typedef struct {
            logic signed [VALUE_BITS-1:0]     removed_value;
            status_t                          status;
            logic        [COUNT_OUT_BITS-1:0] entry_count;
        } outcome_t;

        logic signed [VALUE_BITS-1:0]    value_mem [CAPACITY];
        logic        [PRIORITY_BITS-1:0] prio_mem  [CAPACITY];
        int       held;
        outcome_t awaited [$];
        int       mismatches;
        int       inserts;
        int       full_refusals;
        int       removes;
        int       empty_refusals;
        int       peak;

        function int outstanding();
            return awaited.size();
        endfunction

        function void note_request(logic act, logic signed [VALUE_BITS-1:0] val,
                                   logic [PRIO_IN_BITS-1:0] prio);
            outcome_t o;
            int       best;
            o.removed_value = '0;
            o.status        = STATUS_DONE;
            if (act == ACT_INSERT)
            begin
                inserts++;
                if (held >= CAPACITY)
                begin
                    o.status = STATUS_FULL;
                    full_refusals++;
                end
                else
                begin
                    value_mem[held] = val;
                    prio_mem[held]  = prio[PRIORITY_BITS-1:0];
                    held++;
                    if (held > peak)
                        peak = held;
                end
            end
            else
            begin
                removes++;
                if (held == 0)
                begin
                    o.status = STATUS_EMPTY;
                    empty_refusals++;
                end
                else
                begin
                    // Strict compare keeps the earliest entry on a tie.
                    best = 0;
                    for (int i = 1; i < held; i++)
                        if (prio_mem[i] > prio_mem[best])
                            best = i;
                    o.removed_value = value_mem[best];
                    for (int i = best; i < held - 1; i++)
                    begin
                        value_mem[i] = value_mem[i + 1];
                        prio_mem[i]  = prio_mem[i + 1];
                    end
                    held--;
                end
            end
            o.entry_count = COUNT_OUT_BITS'(held);
            awaited.push_back(o);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, what);
        endfunction

        function void check_response(logic signed [VALUE_BITS-1:0] val,
                                     logic [STATUS_BITS-1:0] st,
                                     logic [COUNT_OUT_BITS-1:0] cnt);
            outcome_t o;
            if (awaited.size() == 0)
            begin
                flag($sformatf("response with nothing outstanding: value=%0d status=%0d count=%0d",
                               val, st, cnt));
                return;
            end
            o = awaited.pop_front();
            if (val !== o.removed_value || st !== o.status || cnt !== o.entry_count)
                flag($sformatf({"expected value=%0d status=%s count=%0d, ",
                                "got value=%0d status=%0d count=%0d"},
                               o.removed_value, o.status.name(), o.entry_count,
                               val, st, cnt));
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic                               action;
    logic signed [VALUE_BITS-1:0]       item_value;
    logic        [PRIO_IN_BITS-1:0]     item_priority;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [VALUE_BITS-1:0]       removed_value;
    logic        [STATUS_BITS-1:0]      status;
    logic        [COUNT_OUT_BITS-1:0]   entry_count;

    pq_scoreboard sb;
    int           idle_pct;
    int           stall_pct;

    // Directed fill pattern: the value extremes, the priority extremes and
    // several ties at the top priority so that removal order is exercised.
    logic signed [VALUE_BITS-1:0] fill_values [CAPACITY] = '{
        32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF,
        32'sh00000001, 32'sh55555555, 32'shAAAAAAAA, 32'sh0000FFFF,
        32'shFFFF0000, 32'sh12345678, 32'shEDCBA987, 32'sh7FFFFFFE,
        32'sh80000001, 32'sh0F0F0F0F, 32'shF0F0F0F0, 32'sh00000100
    };
    logic [PRIO_IN_BITS-1:0] fill_prios [CAPACITY] = '{
        8'd0,   8'd255, 8'd255, 8'd7,   8'd0,   8'd128, 8'd255, 8'd1,
        8'd254, 8'd127, 8'd0,   8'd128, 8'd255, 8'd3,   8'd3,   8'd200
    };

    priority_queue_linear_scan #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .removed_value (removed_value),
        .status        (status),
        .entry_count   (entry_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // The sink stalls at random with the probability of the current phase.
    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Both channels are observed at the clock edge, before any testbench or
    // block update of that edge takes effect. A request is handed to the
    // scoreboard in the cycle it is accepted; a response is checked in the
    // cycle it is taken by the sink.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(action, item_value, item_priority);
            if (out_valid && !out_stall)
                sb.check_response(removed_value, status, entry_count);
        end
    end

    // Presents one request transaction and holds it until accepted. Before
    // the request the source may idle for a random number of cycles.
    task automatic send_request(input logic act, input logic signed [VALUE_BITS-1:0] val,
                                input logic [PRIO_IN_BITS-1:0] prio);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        item_value    <= val;
        item_priority <= prio;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Holds the source off until every outstanding response has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Random traffic in bursts. Each burst leans toward filling, draining or
    // a balanced mix, so the queue swings between full and empty often, and
    // picks a priority style: a narrow range for many ties, only the two
    // extremes, or the full range. Fields that a remove ignores stay random.
    task automatic run_traffic(input int count);
        int                      burst_left;
        int                      insert_pct;
        int                      prio_style;
        logic                    act;
        logic [PRIO_IN_BITS-1:0] prio;
        burst_left = 0;
        insert_pct = 50;
        prio_style = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 20;
                    default: insert_pct = 50;
                endcase
                prio_style = $urandom_range(3);
            end
            burst_left--;
            act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
            case (prio_style)
                0:       prio = PRIO_IN_BITS'($urandom_range(3));
                1:       prio = $urandom_range(1) ? 8'hFF : 8'h00;
                default: prio = PRIO_IN_BITS'($urandom_range(255));
            endcase
            send_request(act, $urandom, prio);
            if ($urandom_range(199) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        sb             = new;
        idle_pct       = 0;
        stall_pct      = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        action        <= ACT_INSERT;
        item_value    <= '0;
        item_priority <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A remove on the empty queue must be refused.
        send_request(ACT_REMOVE, 32'sh5A5A5A5A, 8'hFF);
        // Fill to capacity, then one more insert that must be refused.
        for (int i = 0; i < CAPACITY; i++)
            send_request(ACT_INSERT, fill_values[i], fill_prios[i]);
        send_request(ACT_INSERT, 32'sh12345678, 8'hFF);
        // The four top-priority entries come out in insertion order, then
        // the next highest priority follows.
        repeat (5)
            send_request(ACT_REMOVE, $urandom, PRIO_IN_BITS'($urandom_range(255)));
        wait_drained();

        // Random part under four idle and stall mixes. Between mixes the
        // source waits until every response is back.
        run_traffic(PHASE_ITEMS);
        wait_drained();
        idle_pct  = 58;
        stall_pct = 0;
        run_traffic(PHASE_ITEMS);
        wait_drained();
        idle_pct  = 0;
        stall_pct = 58;
        run_traffic(PHASE_ITEMS);
        wait_drained();
        idle_pct  = 26;
        stall_pct = 26;
        run_traffic(PHASE_ITEMS);

        wait_drained();
        stall_pct = 0;
        // Any stray response after the last expected one would show up here.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d inserts (%0d refused as full) and %0d removes (%0d refused as empty).",
                 sb.inserts, sb.full_refusals, sb.removes, sb.empty_refusals);
        $display("Peak occupancy %0d of %0d; %0d mismatching responses.",
                 sb.peak, CAPACITY, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every remove
    // at its longest scan and every transaction waiting out long stalls.
    initial
    begin
        #(2 * HALF_PERIOD * 1_000_000);
        $display("Watchdog expired with %0d responses outstanding.", sb.outstanding());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pqls_pkg.sv
design/pqls_ram.sv
design/priority_queue_linear_scan.sv
dv/priority_queue_linear_scan_tb.sv
